[sv/rrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

   // Default sizes of the length accumulator and the reply counter
   localparam int DEF_LEN_BITS   = 32;
   localparam int DEF_COUNT_BITS = 16;

   // Fixed port widths
   localparam int BYTE_BITS   = 8;
   localparam int STATUS_BITS = 3;
   localparam int SEEN_BITS   = 16;
   localparam int EXPECT_BITS = 16;

   localparam logic [EXPECT_BITS-1:0] EXPECT_RESET = EXPECT_BITS'(1);

   // Characters of the reply syntax
   localparam logic [BYTE_BITS-1:0] CH_PLUS   = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_BITS-1:0] CH_MINUS  = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_BITS-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_BUSY      = 3'd0,
      ST_DONE      = 3'd1,
      ST_ERR_REPLY = 3'd2,
      ST_BAD_LEN   = 3'd3,
      ST_BAD_TYPE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,   // first byte of a header line
      PH_SIMPLE = 3'd1,   // rest of a '+' or ':' line
      PH_NUM    = 3'd2,   // decimal length of '$' or '*'
      PH_TOERR  = 3'd3,   // line that ends in an error status
      PH_BULK   = 3'd4,   // skipping bulk payload bytes
      PH_ARRAY  = 3'd5    // skipping array lines
   } phase_type;

   // Reply kind: in PH_NUM it tells bulk from array; in PH_TOERR it picks
   // the error status (bulk slot for an error reply, array slot for a bad
   // number, other for an unexpected type byte).
   typedef enum logic [1:0] {
      RK_BULK  = 2'd0,
      RK_ARRAY = 2'd1,
      RK_OTHER = 2'd2
   } kind_type;

   typedef struct packed {
      status_type            status;
      logic [SEEN_BITS-1:0]  replies_seen;
   } rrc_result_type;

endpackage

`default_nettype wire

[sv/rrc_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rrc_req_if
   import rrc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [BYTE_BITS-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/rrc_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rrc_rsp_if
   import rrc_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [STATUS_BITS-1:0]  status;
   logic [SEEN_BITS-1:0]    replies_seen;

   modport source (output valid, output status, output replies_seen, input ready);
   modport sink   (input valid, input status, input replies_seen, output ready);
endinterface

`default_nettype wire

[sv/resp_reply_counter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Reply counter for a line-based request/reply byte stream. Each byte taken
// on req_bus yields one word on rsp_bus with the current status (busy, done,
// error reply, bad length, unexpected type) and the number of complete
// replies so far; once the status leaves busy it sticks and bytes are still
// answered but ignored. The unit takes one byte per clock cycle while rsp_bus
// accepts words; back-pressure on rsp_bus stalls the input. Each byte is held
// in the input register, then the parser update loads the result register,
// which presents the word on rsp_bus. That update, a state change plus a
// multiply-by-ten on the length accumulator, is the step that sets the rate.
// Writing csr_wdata with csr_we sets the number of replies to wait for and
// restarts the check; write it only while no word is in flight.
module resp_reply_counter_unit
   import rrc_pkg::*;
#(
   parameter int LEN_BITS   = DEF_LEN_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   rrc_req_if.sink                      req_bus,
   rrc_rsp_if.source                    rsp_bus,
   input  wire logic                    csr_we,
   input  wire logic [EXPECT_BITS-1:0]  csr_wdata
);

   logic                  held_valid;
   logic [BYTE_BITS-1:0]  held_byte;
   logic                  has_room;
   logic                  advance;
   rrc_result_type        next_word;
   rrc_result_type        out_word;

   // Move the held byte into the parser when the result register has room
   assign advance = held_valid && has_room;

   rrc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_byte   (req_bus.rx_byte),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   rrc_parser #(
      .LEN_BITS   (LEN_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (held_byte),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (next_word)
   );

   rrc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_word (next_word),
      .has_room  (has_room),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_word  (out_word)
   );

   // Drive the result payload
   assign rsp_bus.status       = out_word.status;
   assign rsp_bus.replies_seen = out_word.replies_seen;

endmodule

`default_nettype wire

[sv/rrc_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_in_stage
   import rrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_BITS-1:0]  req_byte,
   input  wire logic                  advance,
   output logic                       held_valid,
   output logic [BYTE_BITS-1:0]       held_byte
);

   logic                  valid_ff, valid_in;
   logic [BYTE_BITS-1:0]  byte_ff, byte_in;
   logic                  take;

   // Take a new word whenever the register is empty or moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = take || (valid_ff && !advance);
      byte_in  = take ? req_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

`default_nettype wire

[sv/rrc_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_parser
   import rrc_pkg::*;
#(
   parameter int LEN_BITS   = DEF_LEN_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [BYTE_BITS-1:0]    rx_byte,
   input  wire logic                    csr_we,
   input  wire logic [EXPECT_BITS-1:0]  csr_wdata,
   output rrc_result_type               result
);

   localparam int AccBits = LEN_BITS + 1;
   localparam int MulBits = LEN_BITS + 5;
   localparam int ExtBits = (COUNT_BITS > SEEN_BITS) ?
                            ((COUNT_BITS > EXPECT_BITS) ? COUNT_BITS : EXPECT_BITS) :
                            ((SEEN_BITS > EXPECT_BITS) ? SEEN_BITS : EXPECT_BITS);
   localparam logic [MulBits-1:0]    LenLimit = MulBits'(1) << LEN_BITS;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
   localparam logic [AccBits-1:0]    AccOne   = AccBits'(1);
   localparam logic [AccBits-1:0]    AccTwo   = AccBits'(2);

   phase_type               phase_ff, phase_in;
   kind_type                kind_ff, kind_in;
   logic [AccBits-1:0]      acc_ff, acc_in;
   logic                    digit_ff, digit_in;
   logic                    minus_ff, minus_in;
   logic                    crp_ff, crp_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   status_type              status_ff, status_in;
   logic [EXPECT_BITS-1:0]  expect_ff, expect_in;

   logic                    finish;
   logic                    line_end;
   logic [MulBits-1:0]      acc_wide;
   logic [MulBits-1:0]      acc_times_ten;
   logic                    is_digit;
   logic                    bad_len;
   logic [ExtBits-1:0]      count_ext;
   logic [ExtBits-1:0]      expect_ext;

   // Length accumulator times ten plus the digit (clamped at the limit on update), digit test and length check
   always_comb begin
      acc_wide      = MulBits'(acc_ff);
      acc_times_ten = (acc_wide << 3) + (acc_wide << 1)
                    + MulBits'(rx_byte[3:0]);
      is_digit      = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
      bad_len       = !digit_ff || acc_ff[LEN_BITS] || (minus_ff && (acc_ff != AccOne));
   end

   // Next state of the parser
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      acc_in     = acc_ff;
      digit_in   = digit_ff;
      minus_in   = minus_ff;
      crp_in     = crp_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      expect_in  = expect_ff;
      finish     = 1'b0;
      line_end   = 1'b0;
      count_ext  = '0;
      expect_ext = '0;

      if (csr_we) begin
         // restart the check with a new reply target
         expect_in = csr_wdata;
         phase_in  = PH_FIRST;
         kind_in   = RK_BULK;
         acc_in    = '0;
         digit_in  = 1'b0;
         minus_in  = 1'b0;
         crp_in    = 1'b0;
         count_in  = '0;
         status_in = ST_BUSY;
      end else if (step && (status_ff == ST_BUSY)) begin
         unique case (phase_ff)
            PH_FIRST: begin
               if ((rx_byte == CH_PLUS) || (rx_byte == CH_COLON)) begin
                  phase_in = PH_SIMPLE;
               end else if (rx_byte == CH_MINUS) begin
                  phase_in = PH_TOERR;
                  kind_in  = RK_BULK;
               end else if ((rx_byte == CH_DOLLAR) || (rx_byte == CH_STAR)) begin
                  phase_in = PH_NUM;
                  kind_in  = (rx_byte == CH_STAR) ? RK_ARRAY : RK_BULK;
               end else begin
                  phase_in = PH_TOERR;
                  kind_in  = RK_OTHER;
                  crp_in   = (rx_byte == CH_CR);
               end
            end
            PH_BULK: begin
               acc_in = acc_ff - AccOne;
               finish = (acc_ff == AccOne);
            end
            PH_ARRAY: begin
               if (crp_ff && (rx_byte == CH_LF)) begin
                  crp_in = 1'b0;
                  acc_in = acc_ff - AccOne;
                  finish = (acc_ff == AccOne);
               end else begin
                  crp_in = (rx_byte == CH_CR);
               end
            end
            PH_SIMPLE, PH_NUM, PH_TOERR: begin
               if (crp_ff && (rx_byte == CH_LF)) begin
                  crp_in   = 1'b0;
                  line_end = 1'b1;
               end else begin
                  // a held CR that is not followed by LF is line content
                  if (crp_ff) begin
                     crp_in = 1'b0;
                     if (phase_ff == PH_NUM) begin
                        phase_in = PH_TOERR;
                        kind_in  = RK_ARRAY;
                     end
                  end
                  if (rx_byte == CH_CR) begin
                     crp_in = 1'b1;
                  end else if (phase_in == PH_NUM) begin
                     if (is_digit) begin
                        digit_in = 1'b1;
                        acc_in   = (acc_times_ten > LenLimit) ? AccBits'(LenLimit) :
                                   AccBits'(acc_times_ten);
                     end else if ((rx_byte == CH_MINUS) && !digit_ff && !minus_ff) begin
                        minus_in = 1'b1;
                     end else begin
                        phase_in = PH_TOERR;
                        kind_in  = RK_ARRAY;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase

         // resolve a completed header line
         if (line_end) begin
            case (phase_ff)
               PH_SIMPLE: begin
                  finish = 1'b1;
               end
               PH_TOERR: begin
                  case (kind_ff)
                     RK_BULK:  status_in = ST_ERR_REPLY;
                     RK_ARRAY: status_in = ST_BAD_LEN;
                     default:  status_in = ST_BAD_TYPE;
                  endcase
               end
               default: begin
                  if (bad_len) begin
                     status_in = ST_BAD_LEN;
                  end else if (minus_ff) begin
                     finish = 1'b1;
                  end else if (kind_ff == RK_BULK) begin
                     acc_in   = acc_ff + AccTwo;
                     phase_in = PH_BULK;
                  end else if (acc_ff == '0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_ARRAY;
                  end
               end
            endcase
         end

         // count the reply and clear the parser
         if (finish) begin
            count_in = (count_ff != CountMax) ? (count_ff + COUNT_BITS'(1)) : count_ff;
            phase_in = PH_FIRST;
            kind_in  = RK_BULK;
            acc_in   = '0;
            digit_in = 1'b0;
            minus_in = 1'b0;
            crp_in   = 1'b0;
         end
         count_ext  = ExtBits'(count_in);
         expect_ext = ExtBits'(expect_ff);
         if (finish && (count_ext >= expect_ext)) begin
            status_in = ST_DONE;
         end
      end
   end

   // Result word from the updated state
   always_comb begin
      result.status       = status_in;
      result.replies_seen = SEEN_BITS'(ExtBits'(count_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         kind_ff   <= RK_BULK;
         acc_ff    <= '0;
         digit_ff  <= 1'b0;
         minus_ff  <= 1'b0;
         crp_ff    <= 1'b0;
         count_ff  <= '0;
         status_ff <= ST_BUSY;
         expect_ff <= EXPECT_RESET;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         acc_ff    <= acc_in;
         digit_ff  <= digit_in;
         minus_ff  <= minus_in;
         crp_ff    <= crp_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         expect_ff <= expect_in;
      end
   end

endmodule

`default_nettype wire

[sv/rrc_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_out_stage
   import rrc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire rrc_result_type  load_word,
   output logic                 has_room,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rrc_result_type       rsp_word
);

   logic            valid_ff, valid_in;
   rrc_result_type  word_ff, word_in;

   // Room for a new word when empty or the held word leaves now
   assign has_room = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_ready);
      word_in  = load ? load_word : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire
